// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define HFWS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define HFWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/hfws_pkg.sv -----
// shared codes, constants and saturation helper for the wave grid
`default_nettype none
package hfws_pkg;

  typedef logic signed [31:0] q16_t;

  // operation codes carried in tuser
  localparam logic [2:0] FUNC_WRITE = 3'd0;
  localparam logic [2:0] FUNC_READ  = 3'd1;
  localparam logic [2:0] FUNC_TICK  = 3'd2;
  localparam logic [2:0] FUNC_PUSH  = 3'd3;
  localparam logic [2:0] FUNC_ADD   = 3'd4;

  localparam logic [15:0] DAMP_RESET = 16'd64880;
  localparam logic [12:0] COUNT_MAX  = 13'h1fff;

  // clamp a wide signed value into q16.16 range
  function automatic q16_t sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/hfws_ram.sv -----
// simple dual-port memory, one write and one registered read per cycle
`default_nettype none
module hfws_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [31:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/height_field_wave_step.sv -----
// top level of the height-field wave grid engine
//
// Heights and velocities of a GRID_SIDE x GRID_SIDE grid live in two single-read-port
// memories. After reset a clearing pass over all GRID_SIDE^2 cells zeroes both, during which
// s_tready stays low. One transaction is processed at a time: write and read touch one
// cell, push and add make one pass over every cell, and tick makes a velocity pass that
// fetches the four neighbour heights and then the centre height of each cell through
// the one height read port, then a second pass that updates every height. A finished
// result sits in an output register so the next transaction can be taken while it waits.
`default_nettype none
module height_field_wave_step import hfws_pkg::*; #(
  parameter int GRID_SIDE = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // row[5:0] col[11:6] write_height[43:12] centre_x[57:44] centre_y[71:58]
  // radius[87:72] amount[119:88]
  input  wire logic [119:0] s_tdata,
  // func[2:0]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // read_height[31:0] read_velocity[63:32] cells_touched[76:64] zero[79:77]
  output logic      [79:0]  m_tdata,
  input  wire logic         damping_we,
  input  wire logic [15:0]  damping_factor
);

  localparam int IDX_W  = $clog2(GRID_SIDE);
  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(GRID_SIDE - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_WRITE  = 4'd2;
  localparam logic [3:0] ST_READ0  = 4'd3;
  localparam logic [3:0] ST_READ1  = 4'd4;
  localparam logic [3:0] ST_TICK_V = 4'd5;
  localparam logic [3:0] ST_TICK_H = 4'd6;
  localparam logic [3:0] ST_DISK   = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(32'(r) * GRID_SIDE + 32'(c));
  endfunction

  logic [3:0]        state;
  logic [2:0]        phase;
  logic [ADDR_W-1:0] clr_addr;
  logic [IDX_W-1:0]  ci;
  logic [IDX_W-1:0]  cj;
  logic [15:0]       damp;

  // latched transaction
  logic [2:0]        func;
  logic              req_valid;
  logic [ADDR_W-1:0] req_addr;
  q16_t              wheight;
  logic [13:0]       cx;
  logic [13:0]       cy;
  logic [31:0]       r2;
  q16_t              amt;

  // datapath registers
  logic signed [33:0] nsum;
  logic signed [34:0] tdiff;
  logic signed [51:0] prod;
  logic [33:0]        dx2;
  logic [33:0]        dy2;

  // result staging
  q16_t        res_h;
  q16_t        res_v;
  logic [12:0] res_cnt;

  // memory ports
  logic              h_we;
  logic              v_we;
  logic [ADDR_W-1:0] h_waddr;
  logic [ADDR_W-1:0] v_waddr;
  logic [31:0]       h_wdata;
  logic [31:0]       v_wdata;
  logic [ADDR_W-1:0] h_raddr;
  logic [ADDR_W-1:0] v_raddr;
  logic [31:0]       h_rdata;
  logic [31:0]       v_rdata;

  logic [IDX_W-1:0]  iu;
  logic [IDX_W-1:0]  id;
  logic [IDX_W-1:0]  jl;
  logic [IDX_W-1:0]  jr;
  logic [ADDR_W-1:0] ck;
  logic              cell_last;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic signed [35:0] dx_sq;
  logic signed [35:0] dy_sq;
  logic [34:0]       dist_sum;
  logic              in_disk;
  logic              accept;
  logic              out_load;
  logic [5:0]        in_row;
  logic [5:0]        in_col;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign in_row   = s_tdata[5:0];
  assign in_col   = s_tdata[11:6];
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // clamped neighbour indices and current cell address
  assign iu        = (ci == '0) ? ci : ci - 1'b1;
  assign id        = (ci == LAST_IDX) ? ci : ci + 1'b1;
  assign jl        = (cj == '0) ? cj : cj - 1'b1;
  assign jr        = (cj == LAST_IDX) ? cj : cj + 1'b1;
  assign ck        = cell_addr(ci, cj);
  assign cell_last = (ci == LAST_IDX) && (cj == LAST_IDX);

  // disk distance terms
  assign dx       = $signed({2'b00, 16'({ci, 8'h00})}) - $signed({4'b0000, cx});
  assign dy       = $signed({2'b00, 16'({cj, 8'h00})}) - $signed({4'b0000, cy});
  assign dx_sq    = dx * dx;
  assign dy_sq    = dy * dy;
  assign dist_sum = 35'(dx2) + 35'(dy2);
  assign in_disk  = 35'(r2) > dist_sum;

  // memory port control
  always_comb begin
    h_we    = 1'b0;
    v_we    = 1'b0;
    h_waddr = ck;
    v_waddr = ck;
    h_wdata = '0;
    v_wdata = '0;
    h_raddr = ck;
    v_raddr = ck;
    unique case (state) inside
      ST_CLEAR: begin
        h_we    = 1'b1;
        v_we    = 1'b1;
        h_waddr = clr_addr;
        v_waddr = clr_addr;
      end
      ST_WRITE: begin
        h_we    = req_valid;
        h_waddr = req_addr;
        h_wdata = wheight;
      end
      ST_READ0, ST_READ1: begin
        h_raddr = req_addr;
        v_raddr = req_addr;
      end
      ST_TICK_V: begin
        case (phase)
          3'd0:    h_raddr = cell_addr(iu, cj);
          3'd1:    h_raddr = cell_addr(id, cj);
          3'd2:    h_raddr = cell_addr(ci, jl);
          3'd3:    h_raddr = cell_addr(ci, jr);
          default: h_raddr = ck;
        endcase
        v_we    = (phase == 3'd7);
        v_wdata = sat32(64'(prod >>> 16));
      end
      ST_TICK_H: begin
        h_we    = (phase == 3'd1);
        h_wdata = sat32(64'($signed(h_rdata)) + 64'($signed(v_rdata)));
      end
      ST_DISK: begin
        h_we    = (phase == 3'd1) && in_disk && (func == FUNC_ADD);
        v_we    = (phase == 3'd1) && in_disk && (func == FUNC_PUSH);
        h_wdata = sat32(64'($signed(h_rdata)) + 64'(amt));
        v_wdata = sat32(64'($signed(v_rdata)) - 64'(amt));
      end
      default: begin
      end
    endcase
  end

  hfws_ram #(.DEPTH(CELLS), .ADDR_W(ADDR_W)) u_height (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  hfws_ram #(.DEPTH(CELLS), .ADDR_W(ADDR_W)) u_velocity (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  // damping register
  always_ff @(posedge clk) begin
    if (rst) begin
      damp <= DAMP_RESET;
    end else if (damping_we) begin
      damp <= damping_factor;
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func      <= s_tuser;
      req_valid <= (32'(in_row) < GRID_SIDE) && (32'(in_col) < GRID_SIDE);
      req_addr  <= ADDR_W'(32'(in_row) * GRID_SIDE + 32'(in_col));
      wheight   <= s_tdata[43:12];
      cx        <= s_tdata[57:44];
      cy        <= s_tdata[71:58];
      r2        <= s_tdata[87:72] * s_tdata[87:72];
      amt       <= s_tdata[119:88];
    end
  end

  // datapath pipeline registers
  always_ff @(posedge clk) begin
    if (state == ST_TICK_V) begin
      case (phase) inside
        3'd1:    nsum <= 34'($signed(h_rdata));
        3'd2, 3'd3, 3'd4: nsum <= nsum + 34'($signed(h_rdata));
        3'd5:    tdiff <= 35'($signed(v_rdata)) + 35'(nsum >>> 2) - 35'($signed(h_rdata));
        3'd6:    prod <= tdiff * $signed({1'b0, damp});
        default: begin
        end
      endcase
    end
    dx2 <= dx_sq[33:0];
    dy2 <= dy_sq[33:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {3'b000, res_cnt, res_v, res_h};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      phase    <= '0;
      clr_addr <= '0;
      ci       <= '0;
      cj       <= '0;
    end else begin
      unique case (state) inside
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_h   <= '0;
            res_v   <= '0;
            res_cnt <= '0;
            phase   <= '0;
            ci      <= '0;
            cj      <= '0;
            case (s_tuser) inside
              FUNC_WRITE:         state <= ST_WRITE;
              FUNC_READ:          state <= ST_READ0;
              FUNC_TICK:          state <= ST_TICK_V;
              FUNC_PUSH, FUNC_ADD: state <= ST_DISK;
              default:            state <= ST_DONE;
            endcase
          end
        end
        ST_WRITE: begin
          state <= ST_DONE;
        end
        ST_READ0: begin
          state <= ST_READ1;
        end
        ST_READ1: begin
          if (req_valid) begin
            res_h <= h_rdata;
            res_v <= v_rdata;
          end
          state <= ST_DONE;
        end
        ST_TICK_V: begin
          phase <= phase + 1'b1;
          if (phase == 3'd7) begin
            cj <= (cj == LAST_IDX) ? '0 : cj + 1'b1;
            if (cj == LAST_IDX) begin
              ci <= (ci == LAST_IDX) ? '0 : ci + 1'b1;
            end
            if (cell_last) begin
              state <= ST_TICK_H;
            end
          end
        end
        ST_TICK_H, ST_DISK: begin
          phase <= (phase == 3'd1) ? 3'd0 : 3'd1;
          if (phase == 3'd1) begin
            if (state == ST_DISK && in_disk && res_cnt != COUNT_MAX) begin
              res_cnt <= res_cnt + 1'b1;
            end
            cj <= (cj == LAST_IDX) ? '0 : cj + 1'b1;
            if (cj == LAST_IDX) begin
              ci <= (ci == LAST_IDX) ? '0 : ci + 1'b1;
            end
            if (cell_last) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hfws_checker.sv -----
// port-level checks for the wave grid, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module hfws_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata
);

  `HFWS_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
  `HFWS_ASSERT(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata), "data moved")
  `HFWS_ASSERT_ALWAYS(a_clear_busy, clk, rst |=> !s_tready, "ready during clearing pass")
  `HFWS_ASSERT(a_one_at_time, clk, rst, s_tvalid && s_tready |=> !s_tready, "second accept")
  `HFWS_ASSERT(a_pad_zero, clk, rst, m_tvalid |-> m_tdata[79:77] == 3'b000, "pad bits set")

endmodule

bind height_field_wave_step hfws_checker u_hfws_checker (.*);
`default_nettype wire
